FILE: rtl/websocket_frame_header_parser_defines.svh
// Assertion helpers used by the file that checks this block.
`ifndef WEBSOCKET_FRAME_HEADER_PARSER_DEFINES_SVH
`define WEBSOCKET_FRAME_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define WSFHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define WSFHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wsfhp_pkg.sv
package wsfhp_pkg;

    localparam int LEN_W       = 63;
    localparam int KEY_W       = 32;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Header byte counts of the variable-length fields.
    localparam int LEN16_BYTES = 2;
    localparam int LEN64_BYTES = 8;
    localparam int KEY_BYTES   = 4;

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [3:0] OPC_CONT   = 4'h0;
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_PONG   = 4'hA;

    localparam logic [2:0] FT_CONT   = 3'd0;
    localparam logic [2:0] FT_TEXT   = 3'd1;
    localparam logic [2:0] FT_BINARY = 3'd2;
    localparam logic [2:0] FT_CLOSE  = 3'd3;
    localparam logic [2:0] FT_PING   = 3'd4;
    localparam logic [2:0] FT_PONG   = 3'd5;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_LEN16   = 3'd2,
        PH_LEN64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    // One received byte with its first-header-byte decode attached.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_ok;
        logic [2:0] frame_type;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_beat_t;

    typedef struct packed {
        logic       known;
        logic [2:0] frame_type;
    } opc_dec_t;

    function automatic opc_dec_t opcode_to_type(logic [3:0] opc);
        opc_dec_t d;
        d.known = 1'b1;
        unique case (opc)
            OPC_CONT:   d.frame_type = FT_CONT;
            OPC_TEXT:   d.frame_type = FT_TEXT;
            OPC_BINARY: d.frame_type = FT_BINARY;
            OPC_CLOSE:  d.frame_type = FT_CLOSE;
            OPC_PING:   d.frame_type = FT_PING;
            OPC_PONG:   d.frame_type = FT_PONG;
            default:
            begin
                d.known      = 1'b0;
                d.frame_type = FT_CONT;
            end
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/wsfhp_ifs.sv
interface wsfhp_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface wsfhp_result_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     kind;
    logic [7:0]                     payload_byte;
    logic [2:0]                     frame_type;
    logic                           final_fragment;
    logic [wsfhp_pkg::LEN_W-1:0]    payload_length;
    logic [wsfhp_pkg::KEY_W-1:0]    masking_key;
    logic                           frame_end;

    modport source (
        output valid, output kind, output payload_byte, output frame_type,
        output final_fragment, output payload_length, output masking_key,
        output frame_end, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input frame_type,
        input final_fragment, input payload_length, input masking_key,
        input frame_end, output ready
    );
endinterface

FILE: rtl/websocket_frame_header_parser.sv
// A taken byte is written into a queue slot, and the back end then loads its result
// beat from the queue head into the result registers.
// One byte per cycle while the result beat is not stalled; a stalled beat holds the
// back end while the two-entry queue takes up to two bytes.
// Reset (rst_n, async, active low) empties the queue, drops any held beat, expects a
// first header byte and clears the error; no clearing pass, ready right after reset.
`include "websocket_frame_header_parser_defines.svh"

module websocket_frame_header_parser (
    input  logic           clk,
    input  logic           rst_n,
    wsfhp_stream_if.sink   stream,
    wsfhp_result_if.source result
);

    // Front: take one stream beat per cycle while the queue has room and decode the
    // frame-opening fields (RSV bits, opcode to frame type) so the back end only selects.
    // Queue: two entries, so the front keeps accepting when the back end stalls.
    // A full queue drops ready, and ready returns in the cycle after the back end
    // drains an entry, since it follows the registered fill count.
    // Back: walk the header phases (first byte, length byte, extended length,
    // masking key, payload), keep the sticky error and hold the result beat.

    wsfhp_pkg::q_beat_t push;
    wsfhp_pkg::q_beat_t pop;
    logic               push_ready;
    logic               pop_ready;
    logic               back_error;

    wsfhp_front u_front (
        .stream     (stream),
        .push_ready (push_ready),
        .push       (push)
    );

    wsfhp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    wsfhp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (pop),
        .pop_ready  (pop_ready),
        .error      (back_error),
        .result     (result)
    );

    // Once raised, the error holds until reset.
    `WSFHP_ASSERT_NXT(a_error_sticky, clk, rst_n, back_error, back_error,
                      "protocol error flag dropped")

    // The back end refuses a queued byte only while its result beat is stalled.
    `WSFHP_ASSERT_IMP(a_pop_stall, clk, rst_n, pop.valid && !pop_ready,
                      result.valid && !result.ready,
                      "queue stalled without output stall")

    // An error beat never closes a frame.
    `WSFHP_ASSERT_IMP(a_end_kind, clk, rst_n, result.valid && result.frame_end,
                      result.kind != wsfhp_pkg::KIND_ERROR,
                      "frame end on error beat")

    // An error beat shown implies the parser holds the error.
    `WSFHP_ASSERT_IMP(a_error_kind, clk, rst_n,
                      result.valid && result.kind == wsfhp_pkg::KIND_ERROR, back_error,
                      "error beat without error flag")

endmodule

FILE: rtl/wsfhp_front.sv
module wsfhp_front (
    wsfhp_stream_if.sink       stream,
    input  logic               push_ready,
    output wsfhp_pkg::q_beat_t push
);

    wsfhp_pkg::opc_dec_t opc_dec;

    // Decode the byte as if it opened a frame; the back end uses it only then.
    assign opc_dec = wsfhp_pkg::opcode_to_type(stream.data_byte[3:0]);

    assign push.valid                 = stream.valid;
    assign push.entry.data_byte       = stream.data_byte;
    assign push.entry.first_ok        = opc_dec.known && (stream.data_byte[6:4] == 3'b000);
    assign push.entry.frame_type      = opc_dec.frame_type;
    assign stream.ready               = push_ready;

endmodule

FILE: rtl/wsfhp_queue.sv
module wsfhp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  wsfhp_pkg::q_beat_t push,
    output logic               push_ready,
    output wsfhp_pkg::q_beat_t pop,
    input  logic               pop_ready
);

    localparam logic [wsfhp_pkg::QPTR_W-1:0] LAST_SLOT =
        wsfhp_pkg::QPTR_W'(wsfhp_pkg::QUEUE_DEPTH - 1);
    localparam logic [wsfhp_pkg::QCNT_W-1:0] FULL_CNT =
        wsfhp_pkg::QCNT_W'(wsfhp_pkg::QUEUE_DEPTH);

    wsfhp_pkg::entry_t                slot_reg [wsfhp_pkg::QUEUE_DEPTH];
    logic [wsfhp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [wsfhp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [wsfhp_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign do_push    = push.valid && push_ready;
    assign pop.valid  = (count_reg != '0);
    assign pop.entry  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop.valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

FILE: rtl/wsfhp_back.sv
module wsfhp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  wsfhp_pkg::q_beat_t pop,
    output logic               pop_ready,
    output logic               error,
    wsfhp_result_if.source     result
);

    localparam int LW = wsfhp_pkg::LEN_W;
    localparam int CW = wsfhp_pkg::CNT_W;

    wsfhp_pkg::phase_t       phase_reg, phase_next;
    logic                    error_reg, error_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [LW-1:0]           length_reg, length_next;
    logic [LW-1:0]           remain_reg, remain_next;
    logic [wsfhp_pkg::KEY_W-1:0] mask_reg, mask_next;
    logic                    fin_reg, fin_next;
    logic [2:0]              type_reg, type_next;

    logic                    out_valid_reg, out_valid_next;
    wsfhp_pkg::kind_t        kind_reg, kind_next;
    logic [7:0]              pbyte_reg, pbyte_next;
    logic                    end_reg, end_next;

    logic                    fire;
    logic [7:0]              data;
    logic [6:0]              len7;
    logic                    count_last;
    logic                    length_zero;
    logic                    remain_last;
    logic [LW-1:0]           length_shift;
    logic                    length_top;

    assign pop_ready    = !out_valid_reg || result.ready;
    assign fire         = pop.valid && pop_ready;
    assign data         = pop.entry.data_byte;
    assign len7         = data[6:0];
    assign length_zero  = (length_reg == '0);
    assign remain_last  = (remain_reg[LW-1:1] == '0);
    assign length_shift = {length_reg[LW-9:0], data};
    // Bit 63 of the shifted 64-bit length, which the register does not keep.
    assign length_top   = length_reg[LW-8];

    always_comb
    begin
        case (phase_reg)
            wsfhp_pkg::PH_LEN16: count_last = (count_reg == CW'(wsfhp_pkg::LEN16_BYTES - 1));
            wsfhp_pkg::PH_LEN64: count_last = (count_reg == CW'(wsfhp_pkg::LEN64_BYTES - 1));
            wsfhp_pkg::PH_KEY:   count_last = (count_reg == CW'(wsfhp_pkg::KEY_BYTES - 1));
            default:             count_last = 1'b0;
        endcase
    end

    // Next phase and sticky error.
    always_comb
    begin
        phase_next = phase_reg;
        error_next = error_reg;
        if (fire && !error_reg)
        begin
            unique case (phase_reg) inside
                wsfhp_pkg::PH_FIRST:
                begin
                    if (!pop.entry.first_ok)
                        error_next = 1'b1;
                    else
                        phase_next = wsfhp_pkg::PH_SECOND;
                end
                wsfhp_pkg::PH_SECOND:
                begin
                    if (!data[7])
                        error_next = 1'b1;
                    else if (len7 == wsfhp_pkg::LEN7_EXT16)
                        phase_next = wsfhp_pkg::PH_LEN16;
                    else if (len7 == wsfhp_pkg::LEN7_EXT64)
                        phase_next = wsfhp_pkg::PH_LEN64;
                    else
                        phase_next = wsfhp_pkg::PH_KEY;
                end
                wsfhp_pkg::PH_LEN16, wsfhp_pkg::PH_LEN64:
                begin
                    if (count_last)
                    begin
                        if (length_top)
                            error_next = 1'b1;
                        else
                            phase_next = wsfhp_pkg::PH_KEY;
                    end
                end
                wsfhp_pkg::PH_KEY:
                begin
                    if (count_last)
                        phase_next = length_zero ? wsfhp_pkg::PH_FIRST
                                                 : wsfhp_pkg::PH_PAYLOAD;
                end
                wsfhp_pkg::PH_PAYLOAD:
                begin
                    if (remain_last)
                        phase_next = wsfhp_pkg::PH_FIRST;
                end
                default:
                begin
                    phase_next = wsfhp_pkg::PH_FIRST;
                end
            endcase
        end
    end

    // Header registers and the result beat.
    always_comb
    begin
        count_next     = count_reg;
        length_next    = length_reg;
        remain_next    = remain_reg;
        mask_next      = mask_reg;
        fin_next       = fin_reg;
        type_next      = type_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        pbyte_next     = pbyte_reg;
        end_next       = end_reg;

        if (fire && !error_reg)
        begin
            unique case (phase_reg) inside
                wsfhp_pkg::PH_FIRST:
                begin
                    fin_next    = data[7];
                    type_next   = pop.entry.frame_type;
                    length_next = '0;
                    mask_next   = '0;
                    remain_next = '0;
                    count_next  = '0;
                end
                wsfhp_pkg::PH_SECOND:
                begin
                    count_next = '0;
                    if (len7 != wsfhp_pkg::LEN7_EXT16 && len7 != wsfhp_pkg::LEN7_EXT64)
                        length_next = {(LW - 7)'(0), len7};
                end
                wsfhp_pkg::PH_LEN16, wsfhp_pkg::PH_LEN64:
                begin
                    length_next = length_shift;
                    count_next  = count_last ? '0 : count_reg + 1'b1;
                end
                wsfhp_pkg::PH_KEY:
                begin
                    mask_next  = {mask_reg[wsfhp_pkg::KEY_W-9:0], data};
                    count_next = count_last ? '0 : count_reg + 1'b1;
                    if (count_last)
                        remain_next = length_reg;
                end
                wsfhp_pkg::PH_PAYLOAD:
                begin
                    if (remain_reg != '0)
                        remain_next = remain_reg - 1'b1;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
            if (error_next)
            begin
                kind_next  = wsfhp_pkg::KIND_ERROR;
                pbyte_next = '0;
                end_next   = 1'b0;
            end
            else if (phase_reg == wsfhp_pkg::PH_PAYLOAD)
            begin
                kind_next  = wsfhp_pkg::KIND_PAYLOAD;
                pbyte_next = data;
                end_next   = remain_last;
            end
            else
            begin
                kind_next  = wsfhp_pkg::KIND_HEADER;
                pbyte_next = '0;
                end_next   = (phase_reg == wsfhp_pkg::PH_KEY) && count_last && length_zero;
            end
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wsfhp_pkg::PH_FIRST;
            error_reg     <= 1'b0;
            count_reg     <= '0;
            fin_reg       <= 1'b0;
            type_reg      <= wsfhp_pkg::FT_CLOSE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            error_reg     <= error_next;
            count_reg     <= count_next;
            fin_reg       <= fin_next;
            type_reg      <= type_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        length_reg <= length_next;
        remain_reg <= remain_next;
        mask_reg   <= mask_next;
        kind_reg   <= kind_next;
        pbyte_reg  <= pbyte_next;
        end_reg    <= end_next;
    end

    // Header registers change only when a beat is loaded, so they match the held beat.
    assign result.valid          = out_valid_reg;
    assign result.kind           = kind_reg;
    assign result.payload_byte   = pbyte_reg;
    assign result.frame_end      = end_reg;
    assign result.frame_type     = error_reg ? 3'd0 : type_reg;
    assign result.final_fragment = error_reg ? 1'b0 : fin_reg;
    assign result.payload_length = error_reg ? '0 : length_reg;
    assign result.masking_key    = error_reg ? '0 : mask_reg;
    assign error                 = error_reg;

endmodule
